@@ sv/ezmlr_pkg.sv @@
package ezmlr_pkg;

   typedef enum logic [2:0] {
      ZONE_0 = 3'd0,
      ZONE_1 = 3'd1,
      ZONE_2 = 3'd2,
      ZONE_3 = 3'd3,
      ZONE_4 = 3'd4,
      ZONE_5 = 3'd5,
      ZONE_6 = 3'd6,
      ZONE_7 = 3'd7
   } zone_type;

   typedef enum logic {
      ACTION_LOAD = 1'b0,
      ACTION_STEP = 1'b1
   } action_type;

endpackage

@@ sv/ezmlr_setup.sv @@
module ezmlr_setup
   import ezmlr_pkg::*;
#(
   parameter int CW = 9
) (
   input  logic signed [CW-1:0] start_x,
   input  logic signed [CW-1:0] start_y,
   input  logic signed [CW-1:0] end_x,
   input  logic signed [CW-1:0] end_y,
   output zone_type             zone,
   output logic signed [CW:0]   walk_x,
   output logic signed [CW:0]   walk_y,
   output logic signed [CW:0]   stop_x,
   output logic signed [CW+2:0] decision,
   output logic signed [CW+2:0] step_east,
   output logic signed [CW+2:0] step_diag
);

   localparam int DW = CW + 3;

   function automatic logic [2*CW+1:0] to_zero(input zone_type z,
                                                input logic signed [CW:0] x,
                                                input logic signed [CW:0] y);
      logic signed [CW:0] u;
      logic signed [CW:0] v;
      begin
         unique case (z)
            ZONE_0: begin u = x;  v = y;  end
            ZONE_1: begin u = y;  v = x;  end
            ZONE_2: begin u = y;  v = -x; end
            ZONE_3: begin u = -x; v = y;  end
            ZONE_4: begin u = -x; v = -y; end
            ZONE_5: begin u = -y; v = -x; end
            ZONE_6: begin u = -y; v = x;  end
            ZONE_7: begin u = x;  v = -y; end
            default: begin u = x; v = y;  end
         endcase
         return {u, v};
      end
   endfunction

   logic signed [CW+1:0] dx;
   logic signed [CW+1:0] dy;
   logic signed [CW+1:0] adx;
   logic signed [CW+1:0] ady;
   logic                 x_major;
   logic [2*CW+1:0]      p0;
   logic [2*CW+1:0]      p1;
   logic signed [CW:0]   u0;
   logic signed [CW:0]   v0;
   logic signed [CW:0]   u1;
   logic signed [CW:0]   v1;
   logic signed [DW-1:0] du;
   logic signed [DW-1:0] dv;

   assign dx      = (CW+2)'(end_x) - (CW+2)'(start_x);
   assign dy      = (CW+2)'(end_y) - (CW+2)'(start_y);
   assign adx     = dx[CW+1] ? -dx : dx;
   assign ady     = dy[CW+1] ? -dy : dy;
   assign x_major = (adx >= ady);

   always_comb begin
      case ({dx[CW+1], dy[CW+1]})
         2'b00:   zone = x_major ? ZONE_0 : ZONE_1;
         2'b10:   zone = x_major ? ZONE_3 : ZONE_2;
         2'b11:   zone = x_major ? ZONE_4 : ZONE_5;
         default: zone = x_major ? ZONE_7 : ZONE_6;
      endcase
   end

   assign p0 = to_zero(zone, (CW+1)'(start_x), (CW+1)'(start_y));
   assign p1 = to_zero(zone, (CW+1)'(end_x), (CW+1)'(end_y));
   assign u0 = $signed(p0[2*CW+1:CW+1]);
   assign v0 = $signed(p0[CW:0]);
   assign u1 = $signed(p1[2*CW+1:CW+1]);
   assign v1 = $signed(p1[CW:0]);

   assign du = DW'(u1) - DW'(u0);
   assign dv = DW'(v1) - DW'(v0);

   assign walk_x    = u0;
   assign walk_y    = v0;
   assign stop_x    = u1;
   assign step_east = dv <<< 1;
   assign decision  = (dv <<< 1) - du;
   assign step_diag = (dv - du) <<< 1;

endmodule

@@ sv/eight_zone_midpoint_line_rasterizer.sv @@
// Midpoint line rasterizer with eight-zone slope symmetry.
// A load request updates the line state in the cycle it is accepted and gives no response.
// A step request on an active line puts its pixel in the response register in the cycle after acceptance.
// Throughput is one request per cycle; a response held by the receiver stalls new requests.
// Synchronous active-high reset clears the active-line flag and the response valid.
module eight_zone_midpoint_line_rasterizer
   import ezmlr_pkg::*;
#(
   parameter int HALF_SPAN = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_action,
   input  logic signed [$clog2(HALF_SPAN):0]    req_start_x,
   input  logic signed [$clog2(HALF_SPAN):0]    req_start_y,
   input  logic signed [$clog2(HALF_SPAN):0]    req_end_x,
   input  logic signed [$clog2(HALF_SPAN):0]    req_end_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [$clog2(HALF_SPAN):0]    rsp_pixel_x,
   output logic signed [$clog2(HALF_SPAN):0]    rsp_pixel_y,
   output logic [2:0]                           rsp_octant,
   output logic                                 rsp_last_pixel
);

   localparam int CW = $clog2(HALF_SPAN) + 1;
   localparam int DW = CW + 3;

   function automatic logic [2*CW-1:0] from_zero(input zone_type z,
                                                 input logic signed [CW:0] u,
                                                 input logic signed [CW:0] v);
      logic signed [CW:0] x;
      logic signed [CW:0] y;
      begin
         unique case (z)
            ZONE_0: begin x = u;  y = v;  end
            ZONE_1: begin x = v;  y = u;  end
            ZONE_2: begin x = -v; y = u;  end
            ZONE_3: begin x = -u; y = v;  end
            ZONE_4: begin x = -u; y = -v; end
            ZONE_5: begin x = -v; y = -u; end
            ZONE_6: begin x = v;  y = -u; end
            ZONE_7: begin x = u;  y = -v; end
            default: begin x = u; y = v;  end
         endcase
         return {x[CW-1:0], y[CW-1:0]};
      end
   endfunction

   zone_type             ld_zone;
   logic signed [CW:0]   ld_walk_x;
   logic signed [CW:0]   ld_walk_y;
   logic signed [CW:0]   ld_stop_x;
   logic signed [DW-1:0] ld_decision;
   logic signed [DW-1:0] ld_step_east;
   logic signed [DW-1:0] ld_step_diag;

   ezmlr_setup #(
      .CW(CW)
   ) u_setup (
      .start_x   (req_start_x),
      .start_y   (req_start_y),
      .end_x     (req_end_x),
      .end_y     (req_end_y),
      .zone      (ld_zone),
      .walk_x    (ld_walk_x),
      .walk_y    (ld_walk_y),
      .stop_x    (ld_stop_x),
      .decision  (ld_decision),
      .step_east (ld_step_east),
      .step_diag (ld_step_diag)
   );

   zone_type             zone_ff, zone_in;
   logic signed [CW:0]   walk_x_ff, walk_x_in;
   logic signed [CW:0]   walk_y_ff, walk_y_in;
   logic signed [CW:0]   stop_x_ff, stop_x_in;
   logic signed [DW-1:0] decision_ff, decision_in;
   logic signed [DW-1:0] step_east_ff, step_east_in;
   logic signed [DW-1:0] step_diag_ff, step_diag_in;
   logic                 active_ff, active_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]        pixel_x_ff, pixel_x_in;
   logic [CW-1:0]        pixel_y_ff, pixel_y_in;
   logic [2:0]           octant_ff, octant_in;
   logic                 last_ff, last_in;

   logic                 accept;
   logic                 do_load;
   logic                 do_emit;
   logic                 is_last;
   logic [2*CW-1:0]      pixel;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign do_load   = accept && (req_action == ACTION_LOAD);
   assign do_emit   = accept && (req_action == ACTION_STEP) && active_ff;
   assign is_last   = (walk_x_ff >= stop_x_ff);
   assign pixel     = from_zero(zone_ff, walk_x_ff, walk_y_ff);

   always_comb begin
      zone_in      = zone_ff;
      walk_x_in    = walk_x_ff;
      walk_y_in    = walk_y_ff;
      stop_x_in    = stop_x_ff;
      decision_in  = decision_ff;
      step_east_in = step_east_ff;
      step_diag_in = step_diag_ff;
      active_in    = active_ff;
      if (do_load) begin
         zone_in      = ld_zone;
         walk_x_in    = ld_walk_x;
         walk_y_in    = ld_walk_y;
         stop_x_in    = ld_stop_x;
         decision_in  = ld_decision;
         step_east_in = ld_step_east;
         step_diag_in = ld_step_diag;
         active_in    = 1'b1;
      end else if (do_emit) begin
         if (is_last) begin
            active_in = 1'b0;
         end else if (decision_ff[DW-1]) begin
            walk_x_in   = walk_x_ff + (CW+1)'(1);
            decision_in = decision_ff + step_east_ff;
         end else begin
            walk_x_in   = walk_x_ff + (CW+1)'(1);
            walk_y_in   = walk_y_ff + (CW+1)'(1);
            decision_in = decision_ff + step_diag_ff;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      pixel_x_in   = pixel_x_ff;
      pixel_y_in   = pixel_y_ff;
      octant_in    = octant_ff;
      last_in      = last_ff;
      if (req_ready) begin
         rsp_valid_in = do_emit;
      end
      if (do_emit) begin
         pixel_x_in = pixel[2*CW-1:CW];
         pixel_y_in = pixel[CW-1:0];
         octant_in  = zone_ff;
         last_in    = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      zone_ff      <= zone_in;
      walk_x_ff    <= walk_x_in;
      walk_y_ff    <= walk_y_in;
      stop_x_ff    <= stop_x_in;
      decision_ff  <= decision_in;
      step_east_ff <= step_east_in;
      step_diag_ff <= step_diag_in;
      pixel_x_ff   <= pixel_x_in;
      pixel_y_ff   <= pixel_y_in;
      octant_ff    <= octant_in;
      last_ff      <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_x    = $signed(pixel_x_ff);
   assign rsp_pixel_y    = $signed(pixel_y_ff);
   assign rsp_octant     = octant_ff;
   assign rsp_last_pixel = last_ff;

endmodule

@@ tb/eight_zone_midpoint_line_rasterizer_tb.sv @@
`timescale 1ns / 100ps

module eight_zone_midpoint_line_rasterizer_tb;
   import ezmlr_pkg::*;

   localparam int HALF_SPAN = 256;
   localparam int CW = 9;
   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      zone_type             zone;
      logic                 last;
   } pixel_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_action = ACTION_LOAD;
   logic signed [CW-1:0] req_start_x = '0;
   logic signed [CW-1:0] req_start_y = '0;
   logic signed [CW-1:0] req_end_x = '0;
   logic signed [CW-1:0] req_end_y = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [CW-1:0] rsp_pixel_x;
   logic signed [CW-1:0] rsp_pixel_y;
   logic [2:0]           rsp_octant;
   logic                 rsp_last_pixel;

   // Line walker state as seen from outside, kept in zone-0 coordinates.
   logic signed [CW:0]   walk_x = '0;
   logic signed [CW:0]   walk_y = '0;
   logic signed [CW:0]   stop_x = '0;
   logic signed [11:0]   decision = '0;
   logic signed [11:0]   step_east = '0;
   logic signed [11:0]   step_diag = '0;
   zone_type             line_zone = ZONE_0;
   logic                 line_active = 1'b0;

   pixel_type expected_pixels[$];
   int     mismatches = 0;
   int     items_sent = 0;
   int     send_idle_pct = 0;
   int     rsp_stall_pct = 0;
   int     hold_requests = 0;
   int     hold_served = 0;
   int     hold_left = 0;
   int     quiet_cycles = 0;

   eight_zone_midpoint_line_rasterizer #(
      .HALF_SPAN(HALF_SPAN)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_start_x(req_start_x),
      .req_start_y(req_start_y),
      .req_end_x(req_end_x),
      .req_end_y(req_end_y),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pixel_x(rsp_pixel_x),
      .rsp_pixel_y(rsp_pixel_y),
      .rsp_octant(rsp_octant),
      .rsp_last_pixel(rsp_last_pixel)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic zone_type zone_of(input int dx, input int dy);
      if (dx >= 0 && dy >= 0) return (dx >= dy) ? ZONE_0 : ZONE_1;
      if (dx < 0 && dy >= 0) return (-dx >= dy) ? ZONE_3 : ZONE_2;
      if (dx < 0 && dy < 0) return (-dx >= -dy) ? ZONE_4 : ZONE_5;
      return (dx >= -dy) ? ZONE_7 : ZONE_6;
   endfunction

   function automatic void to_zone0(input zone_type z, input int x, input int y,
                                    output int u, output int v);
      case (z)
         ZONE_0: begin u = x;  v = y;  end
         ZONE_1: begin u = y;  v = x;  end
         ZONE_2: begin u = y;  v = -x; end
         ZONE_3: begin u = -x; v = y;  end
         ZONE_4: begin u = -x; v = -y; end
         ZONE_5: begin u = -y; v = -x; end
         ZONE_6: begin u = -y; v = x;  end
         default: begin u = x; v = -y; end
      endcase
   endfunction

   function automatic void from_zone0(input zone_type z, input int u, input int v,
                                      output int x, output int y);
      case (z)
         ZONE_0: begin x = u;  y = v;  end
         ZONE_1: begin x = v;  y = u;  end
         ZONE_2: begin x = -v; y = u;  end
         ZONE_3: begin x = -u; y = v;  end
         ZONE_4: begin x = -u; y = -v; end
         ZONE_5: begin x = -v; y = -u; end
         ZONE_6: begin x = v;  y = -u; end
         default: begin x = u; y = -v; end
      endcase
   endfunction

   function automatic void predict_pixel(input logic act,
                                         input logic signed [CW-1:0] sx,
                                         input logic signed [CW-1:0] sy,
                                         input logic signed [CW-1:0] ex,
                                         input logic signed [CW-1:0] ey);
      int     u0, v0, u1, v1, px, py;
      logic   last;
      pixel_type p;
      if (act == ACTION_LOAD) begin
         line_zone = zone_of(int'(ex) - int'(sx), int'(ey) - int'(sy));
         to_zone0(line_zone, int'(sx), int'(sy), u0, v0);
         to_zone0(line_zone, int'(ex), int'(ey), u1, v1);
         walk_x = (CW+1)'(u0);
         walk_y = (CW+1)'(v0);
         stop_x = (CW+1)'(u1);
         decision = 12'(2 * (v1 - v0) - (u1 - u0));
         step_east = 12'(2 * (v1 - v0));
         step_diag = 12'(2 * ((v1 - v0) - (u1 - u0)));
         line_active = 1'b1;
      end else if (line_active) begin
         last = (walk_x >= stop_x);
         from_zone0(line_zone, int'(walk_x), int'(walk_y), px, py);
         p.x = CW'(px);
         p.y = CW'(py);
         p.zone = line_zone;
         p.last = last;
         expected_pixels.push_back(p);
         if (last) begin
            line_active = 1'b0;
         end else if (decision < 0) begin
            walk_x = (CW+1)'(walk_x + 1);
            decision = decision + step_east;
         end else begin
            walk_x = (CW+1)'(walk_x + 1);
            walk_y = (CW+1)'(walk_y + 1);
            decision = decision + step_diag;
         end
      end
   endfunction

   task automatic send_request(input logic act,
                               input logic signed [CW-1:0] sx,
                               input logic signed [CW-1:0] sy,
                               input logic signed [CW-1:0] ex,
                               input logic signed [CW-1:0] ey);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x <= ex;
      req_end_y <= ey;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      predict_pixel(act, sx, sy, ex, ey);
   endtask

   task automatic send_load(input int sx, input int sy, input int ex, input int ey);
      send_request(ACTION_LOAD, CW'(sx), CW'(sy), CW'(ex), CW'(ey));
   endtask

   // Step requests carry random endpoint bits, which the block must ignore.
   task automatic send_steps(input int count);
      repeat (count) begin
         send_request(ACTION_STEP, CW'($urandom_range(511)), CW'($urandom_range(511)),
                      CW'($urandom_range(511)), CW'($urandom_range(511)));
      end
   endtask

   function automatic int near(input int s, input int reach);
      int e;
      e = s + int'($urandom_range(2 * reach)) - reach;
      if (e > HALF_SPAN - 1) e = HALF_SPAN - 1;
      if (e < -HALF_SPAN) e = -HALF_SPAN;
      return e;
   endfunction

   task automatic test_step_without_line();
      send_steps(1);
   endtask

   task automatic test_single_pixel_line();
      send_load(0, 0, 0, 0);
      send_steps(2);
   endtask

   task automatic test_extreme_lines();
      send_load(-256, -256, 255, 255);
      send_steps(2);
      send_load(255, -256, -256, 255);
      send_steps(1);
      send_load(255, 255, -256, -256);
      send_steps(1);
      send_load(-256, 255, 255, -256);
      send_steps(1);
   endtask

   task automatic test_each_zone();
      send_load(0, 0, 1, 3);
      send_steps(1);
      send_load(0, 0, -1, 3);
      send_steps(1);
      send_load(0, 0, -1, -3);
      send_steps(1);
      send_load(0, 0, 1, -3);
      send_steps(1);
      send_load(5, -7, 5, -5);
      send_steps(3);
   endtask

   task automatic test_random_lines(input int idle_pct, input int stall_pct,
                                    input int item_goal);
      int first_item, kind, sx, sy, ex, ey, adx, ady, steps;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      first_item = items_sent;
      while (items_sent - first_item < item_goal) begin
         kind = $urandom_range(99);
         if (kind < 8) begin
            send_request(logic'($urandom_range(1)), CW'($urandom_range(511)),
                         CW'($urandom_range(511)), CW'($urandom_range(511)),
                         CW'($urandom_range(511)));
         end else begin
            sx = int'($urandom_range(511)) - HALF_SPAN;
            sy = int'($urandom_range(511)) - HALF_SPAN;
            if (kind < 12) begin
               ex = int'($urandom_range(511)) - HALF_SPAN;
               ey = int'($urandom_range(511)) - HALF_SPAN;
            end else begin
               ex = near(sx, 12);
               ey = near(sy, 12);
            end
            adx = (ex > sx) ? ex - sx : sx - ex;
            ady = (ey > sy) ? ey - sy : sy - ey;
            steps = ((adx > ady) ? adx : ady) + 1;
            if (kind < 20) steps = $urandom_range(steps - 1);
            else steps = steps + $urandom_range(1);
            send_load(sx, sy, ex, ey);
            send_steps(steps);
         end
      end
   endtask

   task automatic test_response_hold();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_load(-256, -10, 255, 60);
      hold_requests++;
      send_steps(80);
   endtask

   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      pixel_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.x = rsp_pixel_x;
         got.y = rsp_pixel_y;
         got.zone = zone_type'(rsp_octant);
         got.last = rsp_last_pixel;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected pixel x=%0d y=%0d zone=%0d last=%0b",
                        got.x, got.y, got.zone, got.last);
         end else begin
            want = expected_pixels.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.zone !== want.zone ||
                got.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("pixel mismatch: expected x=%0d y=%0d zone=%0d last=%0b, %s",
                           want.x, want.y, want.zone, want.last,
                           $sformatf("got x=%0d y=%0d zone=%0d last=%0b",
                                     got.x, got.y, got.zone, got.last));
            end
         end
      end
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_step_without_line();
      test_single_pixel_line();
      test_extreme_lines();
      test_each_zone();
      test_random_lines(0, 0, 400);
      test_random_lines(88, 0, 400);
      test_response_hold();
      test_random_lines(0, 88, 400);
      test_random_lines(27, 27, 400);
      req_valid <= 1'b0;
      wait (expected_pixels.size() == 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ eight_zone_midpoint_line_rasterizer.f @@
sv/ezmlr_pkg.sv
sv/ezmlr_setup.sv
sv/eight_zone_midpoint_line_rasterizer.sv
tb/eight_zone_midpoint_line_rasterizer_tb.sv
